@@ sv/scs_pkg.sv @@
package scs_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW = $clog2(MaxResults + 1);
  localparam int unsigned IdxW = $clog2(MaxResults);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] MODE_C    = 2'd0;
  localparam logic [1:0] MODE_HASH = 2'd1;
  localparam logic [1:0] MODE_NONE = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_t;

  // Results caused by one input beat.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
    logic                       last;   // group ends the stream
    logic                       blank;  // end of stream with nothing kept
  } group_t;

endpackage

@@ sv/source_comment_stripper.sv @@
// Channel | Direction | Payload | Handshake
// in      | input     | in_t    | in_valid / in_stall
// out     | output    | out_t   | out_valid / out_stall
// cfg     | input     | mode    | cfg_we / cfg_wdata
//
// A byte beat is registered, filtered in one pass, and its results (0 to 4)
// land in a result buffer, read out one beat per cycle unless stalled.
// The buffer holds a byte's results until the last is read, so a byte is
// taken every cycle while not stalled and each yields at most one result.
// Reset clears all stream state and sets mode to C comments.
// out_stall holds the buffer, which then stalls the input register.
module source_comment_stripper (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  scs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output scs_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata
);

  scs_pkg::in_t    ireg;
  logic            ireg_valid;
  logic            take;
  logic            free;
  scs_pkg::group_t grp;

  assign take     = ireg_valid && free;
  assign in_stall = ireg_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) ireg_valid <= 1'b0;
    else ireg_valid <= (in_valid && !in_stall) || (ireg_valid && !take);
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) ireg <= in_data;
  end

  scs_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .item      (ireg),
    .grp       (grp)
  );

  scs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (take && grp.cnt != '0),
    .grp_in    (grp),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ sv/scs_filter.sv @@
module scs_filter (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_wdata,
  input  logic            take,
  input  scs_pkg::in_t    item,
  output scs_pkg::group_t grp
);

  typedef struct packed {
    logic       line_act;
    logic       line_hold_v;
    logic       blk_act;
    logic [7:0] blk_hold;
    logic       blk_hold_v;
    logic       hash_act;
    logic       nl_armed;
    logic       trim;
  } st_t;

  typedef struct packed {
    st_t                                 st;
    logic [scs_pkg::MaxResults-1:0][7:0] kept;
    logic [scs_pkg::CntW-1:0]            cnt;
  } wk_t;

  localparam st_t StReset = '{
    line_act: 1'b0, line_hold_v: 1'b0, blk_act: 1'b0, blk_hold: 8'h00,
    blk_hold_v: 1'b0, hash_act: 1'b0, nl_armed: 1'b0, trim: 1'b1
  };

  logic [1:0] mode;
  st_t        st;
  st_t        st_next;
  wk_t        w;

  // Newline-run thinning, leading trim, collect.
  function automatic wk_t fin(wk_t wi, logic [7:0] b);
    wk_t  wo;
    logic drop;
    wo   = wi;
    drop = 1'b0;
    if (b == scs_pkg::CH_NL) begin
      if (wo.st.nl_armed) begin
        wo.st.nl_armed = 1'b0;
        drop = 1'b1;
      end else begin
        wo.st.nl_armed = 1'b1;
      end
    end else begin
      wo.st.nl_armed = 1'b0;
    end
    if (!drop) begin
      if (b == scs_pkg::CH_SPACE || b == scs_pkg::CH_TAB || b == scs_pkg::CH_NL) begin
        if (wo.st.trim) drop = 1'b1;
      end else begin
        wo.st.trim = 1'b0;
      end
    end
    if (!drop && wo.cnt < scs_pkg::CntW'(scs_pkg::MaxResults)) begin
      wo.kept[wo.cnt[scs_pkg::IdxW-1:0]] = b;
      wo.cnt = wo.cnt + 1'b1;
    end
    return wo;
  endfunction

  function automatic wk_t blk_release(wk_t wi, logic [7:0] b);
    wk_t wo;
    wo = wi;
    if (!wo.st.blk_act) wo = fin(wo, b);
    return wo;
  endfunction

  function automatic wk_t blk_feed(wk_t wi, logic [7:0] b);
    wk_t        wo;
    logic [7:0] h;
    logic       done;
    wo   = wi;
    done = 1'b0;
    h    = wo.st.blk_hold;
    if (wo.st.blk_hold_v) begin
      wo.st.blk_hold_v = 1'b0;
      wo.st.blk_hold   = 8'h00;
      if (h == scs_pkg::CH_SLASH && b == scs_pkg::CH_STAR) begin
        wo.st.blk_act = 1'b1;
        done = 1'b1;
      end else if (h == scs_pkg::CH_STAR && b == scs_pkg::CH_SLASH) begin
        wo.st.blk_act = 1'b0;
        done = 1'b1;
      end else begin
        wo = blk_release(wo, h);
      end
    end
    if (!done) begin
      if (b == scs_pkg::CH_SLASH || b == scs_pkg::CH_STAR) begin
        wo.st.blk_hold   = b;
        wo.st.blk_hold_v = 1'b1;
      end else begin
        wo = blk_release(wo, b);
      end
    end
    return wo;
  endfunction

  function automatic wk_t blk_flush(wk_t wi);
    wk_t        wo;
    logic [7:0] h;
    wo = wi;
    h  = wo.st.blk_hold;
    if (wo.st.blk_hold_v) begin
      wo.st.blk_hold_v = 1'b0;
      wo.st.blk_hold   = 8'h00;
      wo = blk_release(wo, h);
    end
    return wo;
  endfunction

  function automatic wk_t line_feed(wk_t wi, logic [7:0] b);
    wk_t  wo;
    logic done;
    wo   = wi;
    done = 1'b0;
    if (wo.st.line_act) begin
      if (b == scs_pkg::CH_NL) begin
        wo.st.line_act = 1'b0;
        wo = blk_feed(wo, b);
      end
    end else begin
      if (wo.st.line_hold_v) begin
        wo.st.line_hold_v = 1'b0;
        if (b == scs_pkg::CH_SLASH) begin
          wo.st.line_act = 1'b1;
          done = 1'b1;
        end else begin
          wo = blk_feed(wo, scs_pkg::CH_SLASH);
        end
      end
      if (!done) begin
        if (b == scs_pkg::CH_SLASH) wo.st.line_hold_v = 1'b1;
        else wo = blk_feed(wo, b);
      end
    end
    return wo;
  endfunction

  function automatic wk_t line_flush(wk_t wi);
    wk_t wo;
    wo = wi;
    if (wo.st.line_hold_v) begin
      wo.st.line_hold_v = 1'b0;
      wo = blk_feed(wo, scs_pkg::CH_SLASH);
    end
    return wo;
  endfunction

  function automatic wk_t hash_feed(wk_t wi, logic [7:0] b);
    wk_t wo;
    wo = wi;
    if (wo.st.hash_act) begin
      if (b == scs_pkg::CH_NL) begin
        wo.st.hash_act = 1'b0;
        wo = fin(wo, b);
      end
    end else if (b == scs_pkg::CH_HASH) begin
      wo.st.hash_act = 1'b1;
    end else begin
      wo = fin(wo, b);
    end
    return wo;
  endfunction

  always_comb begin
    w.st   = st;
    w.kept = '0;
    w.cnt  = '0;
    case (mode)
      scs_pkg::MODE_C: begin
        w = line_feed(w, item.in_byte);
        if (item.in_last) begin
          w = line_flush(w);
          w = blk_flush(w);
        end
      end
      scs_pkg::MODE_HASH: w = hash_feed(w, item.in_byte);
      default:            w = fin(w, item.in_byte);
    endcase

    grp.bytes = w.kept;
    grp.cnt   = w.cnt;
    grp.last  = item.in_last;
    grp.blank = 1'b0;
    if (item.in_last && w.cnt == '0) begin
      grp.cnt   = scs_pkg::CntW'(1);
      grp.blank = 1'b1;
    end

    st_next = item.in_last ? StReset : w.st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= scs_pkg::MODE_C;
      st   <= StReset;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (take) st <= st_next;
    end
  end

endmodule

@@ sv/scs_emit.sv @@
module scs_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  scs_pkg::group_t grp_in,
  output logic            free,
  output logic            out_valid,
  input  logic            out_stall,
  output scs_pkg::out_t   out_data
);

  scs_pkg::group_t          grp;
  logic                     busy;
  logic [scs_pkg::IdxW-1:0] idx;
  logic                     last_entry;
  logic                     beat;

  assign last_entry = ({1'b0, idx} == grp.cnt - 1'b1);
  assign beat       = busy && !out_stall;
  assign free       = !busy || (beat && last_entry);
  assign out_valid  = busy;

  always_comb begin
    out_data.out_byte  = grp.blank ? 8'h00 : grp.bytes[idx];
    out_data.out_valid = !grp.blank;
    out_data.out_last  = grp.last && last_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (beat) begin
      if (last_entry) busy <= 1'b0;
      else idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp <= grp_in;
  end

endmodule
